FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types for the rational arithmetic unit
// Micro-op codes, jump conditions, control word, datapath status flags and
// the microprogram ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} act_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_DEN,
		OP_MUL_NUM,
		OP_MUL_T,
		OP_ADD,
		OP_GCD_LOAD,
		OP_HALVE_BOTH,
		OP_STRIP_X,
		OP_STRIP_Y,
		OP_SUB,
		OP_DIV_LOAD_NUM,
		OP_DIV_STEP,
		OP_DIV_LOAD_DEN,
		OP_DEN_STORE,
		OP_SET_ERR,
		OP_SET_ZERO,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_NO_SUM,
		C_DEN_ZERO,
		C_NUM_ZERO,
		C_BOTH_EVEN,
		C_X_EVEN,
		C_Y_EVEN,
		C_XY_NE,
		C_CNT_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_MUL_T,
		ST_ADD,
		ST_CHECK_DEN,
		ST_CHECK_NUM,
		ST_TWOS,
		ST_STRIP_X,
		ST_STRIP_Y,
		ST_SUB,
		ST_DIV_NUM_LD,
		ST_DIV_NUM,
		ST_DIV_DEN_LD,
		ST_DIV_DEN,
		ST_DEN_STORE,
		ST_ERR,
		ST_ZERO,
		ST_EMIT_WAIT,
		ST_EMIT
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic no_req;
		logic no_sum;
		logic den_zero;
		logic num_zero;
		logic both_even;
		logic x_even;
		logic y_even;
		logic xy_ne;
		logic cnt_more;
		logic out_busy;
	} flags_t;

	// Microprogram: jump to target when the condition holds, else step on.
	function automatic ctrl_t ucode_rom(step_t addr);
		ctrl_t w;
		case (addr)
			ST_IDLE:       w = '{OP_LOAD,         C_NO_REQ,    ST_IDLE};
			ST_MUL_DEN:    w = '{OP_MUL_DEN,      C_NEVER,     ST_IDLE};
			ST_MUL_NUM:    w = '{OP_MUL_NUM,      C_NO_SUM,    ST_CHECK_DEN};
			ST_MUL_T:      w = '{OP_MUL_T,        C_NEVER,     ST_IDLE};
			ST_ADD:        w = '{OP_ADD,          C_NEVER,     ST_IDLE};
			ST_CHECK_DEN:  w = '{OP_GCD_LOAD,     C_DEN_ZERO,  ST_ERR};
			ST_CHECK_NUM:  w = '{OP_NOP,          C_NUM_ZERO,  ST_ZERO};
			ST_TWOS:       w = '{OP_HALVE_BOTH,   C_BOTH_EVEN, ST_TWOS};
			ST_STRIP_X:    w = '{OP_STRIP_X,      C_X_EVEN,    ST_STRIP_X};
			ST_STRIP_Y:    w = '{OP_STRIP_Y,      C_Y_EVEN,    ST_STRIP_Y};
			ST_SUB:        w = '{OP_SUB,          C_XY_NE,     ST_STRIP_X};
			ST_DIV_NUM_LD: w = '{OP_DIV_LOAD_NUM, C_NEVER,     ST_IDLE};
			ST_DIV_NUM:    w = '{OP_DIV_STEP,     C_CNT_MORE,  ST_DIV_NUM};
			ST_DIV_DEN_LD: w = '{OP_DIV_LOAD_DEN, C_NEVER,     ST_IDLE};
			ST_DIV_DEN:    w = '{OP_DIV_STEP,     C_CNT_MORE,  ST_DIV_DEN};
			ST_DEN_STORE:  w = '{OP_DEN_STORE,    C_ALWAYS,    ST_EMIT_WAIT};
			ST_ERR:        w = '{OP_SET_ERR,      C_ALWAYS,    ST_EMIT_WAIT};
			ST_ZERO:       w = '{OP_SET_ZERO,     C_NEVER,     ST_IDLE};
			ST_EMIT_WAIT:  w = '{OP_NOP,          C_OUT_BUSY,  ST_EMIT_WAIT};
			ST_EMIT:       w = '{OP_EMIT,         C_ALWAYS,    ST_IDLE};
			default:       w = '{OP_NOP,          C_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if: request and response channels of the rational arithmetic unit
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_req_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic signed [W-1:0] a_num;
	logic signed [W-1:0] a_den;
	logic signed [W-1:0] b_num;
	logic signed [W-1:0] b_den;

	modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic signed [2*W:0] res_num;
	logic signed [2*W-1:0] res_den;
	logic                zero_den_error;

	modport source (output valid, res_num, res_den, zero_den_error, input ready);
	modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/rau_seq.sv
// ----------------------------------------------------------------------------
// rau_seq: microprogram sequencer
// Step counter, control ROM lookup and conditional jump on datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_seq
	import rau_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output ctrl_t       ctrl
);

	step_t pc_q;
	logic  take;

	assign ctrl = ucode_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_REQ:    take = flags.no_req;
			C_NO_SUM:    take = flags.no_sum;
			C_DEN_ZERO:  take = flags.den_zero;
			C_NUM_ZERO:  take = flags.num_zero;
			C_BOTH_EVEN: take = flags.both_even;
			C_X_EVEN:    take = flags.x_even;
			C_Y_EVEN:    take = flags.y_even;
			C_XY_NE:     take = flags.xy_ne;
			C_CNT_MORE:  take = flags.cnt_more;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= step_t'(pc_q + 5'd1);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, binary gcd and divider
// Executes one micro-op per cycle as the control word selects.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath
	import rau_pkg::*;
#(
	parameter int W = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ctrl_t         ctrl,
	input  wire logic          req_valid,
	input  wire logic [1:0]    action,
	input  wire logic [W-1:0]  a_num,
	input  wire logic [W-1:0]  a_den,
	input  wire logic [W-1:0]  b_num,
	input  wire logic [W-1:0]  b_den,
	input  wire logic          rsp_ready,
	output logic               rsp_valid,
	output logic [2*W:0]       res_num,
	output logic [2*W-1:0]     res_den,
	output logic               zero_den_error,
	output flags_t             flags
);

	localparam int PW = 2 * W;
	localparam int SW = $clog2(PW);

	act_t            act_q;
	logic [W-1:0]    an_q, ad_q, bn_q, bd_q;
	logic            an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [PW-1:0]   num_q, den_q, t_q;
	logic            num_neg_q, den_neg_q, t_neg_q, err_q;
	logic [PW-1:0]   x_q, y_q, d_q, q_q;
	logic [PW:0]     rem_q;
	logic [SW-1:0]   sh_q, cnt_q;
	logic [PW:0]     res_num_q;
	logic [PW-1:0]   res_den_q;
	logic            res_err_q, out_valid_q;

	logic [W-1:0]    mul_a, mul_b;
	logic            mul_neg;
	logic [PW-1:0]   prod;
	logic [PW-1:0]   add_mag;
	logic            add_neg;
	logic [PW:0]     rem_sh, rem_nx;
	logic            fits;
	logic [PW:0]     num_ext;

	function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// Operand select for the shared multiplier.
	always_comb begin
		case (ctrl.op)
			OP_MUL_DEN: begin
				mul_a   = ad_q;
				mul_b   = (act_q == ACT_DIV) ? bn_q : bd_q;
				mul_neg = ad_neg_q ^ ((act_q == ACT_DIV) ? bn_neg_q : bd_neg_q);
			end
			OP_MUL_NUM: begin
				mul_a   = an_q;
				mul_b   = (act_q == ACT_MUL) ? bn_q : bd_q;
				mul_neg = an_neg_q ^ ((act_q == ACT_MUL) ? bn_neg_q : bd_neg_q);
			end
			default: begin
				mul_a   = ad_q;
				mul_b   = bn_q;
				mul_neg = ad_neg_q ^ bn_neg_q ^ (act_q == ACT_SUB);
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// Sign-magnitude add of the two cross products.
	always_comb begin
		if (num_neg_q == t_neg_q) begin
			add_mag = num_q + t_q;
			add_neg = num_neg_q;
		end else if (num_q >= t_q) begin
			add_mag = num_q - t_q;
			add_neg = num_neg_q;
		end else begin
			add_mag = t_q - num_q;
			add_neg = t_neg_q;
		end
	end

	// One restoring-division step.
	assign rem_sh  = {rem_q[PW-1:0], q_q[PW-1]};
	assign fits    = rem_sh >= {1'b0, d_q};
	assign rem_nx  = fits ? (rem_sh - {1'b0, d_q}) : rem_sh;
	assign num_ext = {1'b0, num_q};

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (req_valid) begin
					act_q    <= act_t'(action);
					an_q     <= mag_of(a_num);
					ad_q     <= mag_of(a_den);
					bn_q     <= mag_of(b_num);
					bd_q     <= mag_of(b_den);
					an_neg_q <= a_num[W-1];
					ad_neg_q <= a_den[W-1];
					bn_neg_q <= b_num[W-1];
					bd_neg_q <= b_den[W-1];
					err_q    <= 1'b0;
				end
			end
			OP_MUL_DEN: begin
				den_q     <= prod;
				den_neg_q <= mul_neg;
			end
			OP_MUL_NUM: begin
				num_q     <= prod;
				num_neg_q <= mul_neg;
			end
			OP_MUL_T: begin
				t_q     <= prod;
				t_neg_q <= mul_neg;
			end
			OP_ADD: begin
				num_q     <= add_mag;
				num_neg_q <= add_neg;
			end
			OP_GCD_LOAD: begin
				x_q  <= num_q;
				y_q  <= den_q;
				sh_q <= '0;
			end
			OP_HALVE_BOTH: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q  <= x_q >> 1;
					y_q  <= y_q >> 1;
					sh_q <= sh_q + 1'b1;
				end
			end
			OP_STRIP_X: begin
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end
			end
			OP_STRIP_Y: begin
				if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end
			end
			OP_SUB: begin
				if (x_q > y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			OP_DIV_LOAD_NUM: begin
				d_q   <= x_q << sh_q;
				q_q   <= num_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_nx;
				q_q   <= {q_q[PW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_DIV_LOAD_DEN: begin
				num_q <= q_q;
				q_q   <= den_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_DEN_STORE: begin
				den_q <= q_q;
			end
			OP_SET_ERR: begin
				num_q     <= '0;
				den_q     <= '0;
				num_neg_q <= 1'b0;
				den_neg_q <= 1'b0;
				err_q     <= 1'b1;
			end
			OP_SET_ZERO: begin
				num_q     <= '0;
				den_q     <= PW'(1);
				num_neg_q <= 1'b0;
				den_neg_q <= 1'b0;
			end
			OP_EMIT: begin
				res_num_q <= num_neg_q ? (~num_ext + 1'b1) : num_ext;
				res_den_q <= den_neg_q ? (~den_q + 1'b1) : den_q;
				res_err_q <= err_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign res_num        = res_num_q;
	assign res_den        = res_den_q;
	assign zero_den_error = res_err_q;

	always_comb begin
		flags.no_req    = !req_valid;
		flags.no_sum    = (act_q == ACT_MUL) || (act_q == ACT_DIV);
		flags.den_zero  = (den_q == '0);
		flags.num_zero  = (num_q == '0);
		flags.both_even = !x_q[0] && !y_q[0];
		flags.x_even    = !x_q[0];
		flags.y_even    = !y_q[0];
		flags.xy_ne     = (x_q != y_q);
		flags.cnt_more  = (cnt_q != SW'(PW - 1));
		flags.out_busy  = out_valid_q && !rsp_ready;
	end

endmodule

`default_nettype wire

FILE: rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: add, subtract, multiply or divide two fractions
// Forms the cross products and reduces the result by the gcd of the
// magnitudes; signs stay as the cross products give them.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------
//  req     | in  | valid/ready | action, a_num, a_den, b_num, b_den
//  rsp     | out | valid/ready | res_num, res_den, zero_den_error
//
// One request transaction at a time. A normal item runs fixed steps: the
// cross products on the shared multiplier (plus the add for add and
// subtract) and two restoring divisions, numerator then denominator, plus
// the binary gcd loop, one shift or subtract per cycle. A zero denominator
// skips the gcd and the divisions and gives the error result; a zero
// numerator gives 0/1. The multiplier forms the denominator and numerator
// products, for add and subtract also the second cross product, which then
// goes through the add step. req.ready is high only at the idle step of the
// microprogram; a finished result sits in the output register, so the next
// request is taken while rsp stalls, and the next result waits at the
// emit-wait step until rsp takes the last. Reset clears the step counter
// and the output valid.
`default_nettype none

module rational_arith_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rau_req_if.sink    req,
	rau_rsp_if.source  rsp
);

	ctrl_t  ctrl;
	flags_t flags;

	// Sequencer: step counter walks the control ROM, branching on flags.
	rau_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Accept a request only at the load step.
	assign req.ready = (ctrl.op == OP_LOAD);

	// Datapath: multiplier, sign-magnitude adder, gcd registers, divider,
	// and the output register that holds the result until rsp takes it.
	rau_datapath #(
		.W (OPERAND_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.req_valid      (req.valid),
		.action         (req.action),
		.a_num          (req.a_num),
		.a_den          (req.a_den),
		.b_num          (req.b_num),
		.b_den          (req.b_den),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.res_num        (rsp.res_num),
		.res_den        (rsp.res_den),
		.zero_den_error (rsp.zero_den_error),
		.flags          (flags)
	);

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rational_arith_unit
// Sends fraction pairs through the request channel and works out each
// reduced fraction on the side. It checks every response transaction in order
// and runs through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import rau_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 16;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_PER_PHASE = 410;
	localparam int MAX_REPORTS = 10;

	// One request: the action and the two fractions a_num/a_den, b_num/b_den.
	typedef struct {
		act_t              op;
		logic signed [W-1:0] a_num;
		logic signed [W-1:0] a_den;
		logic signed [W-1:0] b_num;
		logic signed [W-1:0] b_den;
	} frac_pair_t;

	// One response: the reduced fraction and the zero-denominator flag.
	typedef struct {
		logic signed [2*W:0]   num;
		logic signed [2*W-1:0] den;
		logic                  err;
	} reduced_frac_t;

	// Hold the expected fractions in request order and compare responses.
	class fraction_scoreboard;
		reduced_frac_t pending_fracs[$];
		int unsigned   failures;
		int unsigned   reports;

		function new();
			failures = 0;
			reports = 0;
		endfunction

		// Cross-multiply, then divide both parts by the gcd of the magnitudes.
		// Signs stay where the products put them.
		function reduced_frac_t reduced_result(frac_pair_t p);
			longint          n;
			longint          d;
			longint unsigned x;
			longint unsigned y;
			longint unsigned t;
			reduced_frac_t   r;
			case (p.op)
				ACT_ADD: begin
					n = longint'(p.a_num) * longint'(p.b_den) +
						longint'(p.a_den) * longint'(p.b_num);
					d = longint'(p.a_den) * longint'(p.b_den);
				end
				ACT_SUB: begin
					n = longint'(p.a_num) * longint'(p.b_den) -
						longint'(p.a_den) * longint'(p.b_num);
					d = longint'(p.a_den) * longint'(p.b_den);
				end
				ACT_MUL: begin
					n = longint'(p.a_num) * longint'(p.b_num);
					d = longint'(p.a_den) * longint'(p.b_den);
				end
				default: begin
					n = longint'(p.a_num) * longint'(p.b_den);
					d = longint'(p.a_den) * longint'(p.b_num);
				end
			endcase
			r.err = 1'b0;
			if (d == 0) begin
				r.num = '0;
				r.den = '0;
				r.err = 1'b1;
			end else if (n == 0) begin
				r.num = '0;
				r.den = (2*W)'(1);
			end else begin
				x = (n < 0) ? longint'(-n) : n;
				y = (d < 0) ? longint'(-d) : d;
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				n = n / longint'(x);
				d = d / longint'(x);
				r.num = n[2*W:0];
				r.den = d[2*W-1:0];
			end
			return r;
		endfunction

		function void note_request(frac_pair_t p);
			pending_fracs.push_back(reduced_result(p));
		endfunction

		function void check_response(reduced_frac_t got);
			reduced_frac_t exp_frac;
			if (pending_fracs.size() == 0) begin
				failures++;
				if (reports < MAX_REPORTS)
					$display("unexpected response: num=%0d den=%0d err=%0b",
						got.num, got.den, got.err);
				reports++;
				return;
			end
			exp_frac = pending_fracs.pop_front();
			if (got.num !== exp_frac.num || got.den !== exp_frac.den ||
					got.err !== exp_frac.err) begin
				failures++;
				if (reports < MAX_REPORTS)
					$display("mismatch: exp %0d/%0d err=%0b, got %0d/%0d err=%0b",
						exp_frac.num, exp_frac.den, exp_frac.err,
						got.num, got.den, got.err);
				reports++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	fraction_scoreboard sb;

	rau_req_if #(.W(W)) req_if ();
	rau_rsp_if #(.W(W)) rsp_if ();

	rational_arith_unit #(
		.OPERAND_WIDTH(W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the response channel at the rate of the current phase; the
	// value changes on the falling edge only.
	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sample both channels at the rising edge: log accepted requests,
	// check accepted responses, and guard against a hung block.
	always @(posedge clk) begin
		frac_pair_t    p;
		reduced_frac_t r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, sb.pending_fracs.size());
			$display("Verification failed");
			$finish;
		end
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				p.op = act_t'(req_if.action);
				p.a_num = req_if.a_num;
				p.a_den = req_if.a_den;
				p.b_num = req_if.b_num;
				p.b_den = req_if.b_den;
				sb.note_request(p);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				r.num = rsp_if.res_num;
				r.den = rsp_if.res_den;
				r.err = rsp_if.zero_den_error;
				sb.check_response(r);
			end
		end
	end

	// Drive one request transaction. Call at a falling edge; return at the
	// falling edge after the transaction has moved. Hold valid and the
	// payload steady while ready is low.
	task automatic send_pair(frac_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= p.op;
		req_if.a_num <= p.a_num;
		req_if.a_den <= p.a_den;
		req_if.b_num <= p.b_num;
		req_if.b_den <= p.b_den;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_directed(act_t op, int an, int ad, int bn, int bd);
		frac_pair_t p;
		p.op = op;
		p.a_num = an[W-1:0];
		p.a_den = ad[W-1:0];
		p.b_num = bn[W-1:0];
		p.b_den = bd[W-1:0];
		send_pair(p);
	endtask

	// Drop valid and pause until every outstanding response has come back.
	task automatic drain();
		req_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending_fracs.size() != 0);
	endtask

	// Mix full-range values with small ones (shared factors, zeros) and with
	// the extremes, so the reduction and both special cases get exercised.
	function automatic logic signed [W-1:0] random_operand();
		int unsigned pick;
		logic signed [W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 45) begin
			v = W'($urandom());
		end else if (pick < 75) begin
			v = W'($signed($urandom_range(24)) - 12);
		end else if (pick < 85) begin
			case ($urandom_range(4))
				0: v = {1'b1, {(W-1){1'b0}}};
				1: v = {1'b0, {(W-1){1'b1}}};
				2: v = '1;
				3: v = W'(1);
				default: v = '0;
			endcase
		end else begin
			v = W'($urandom_range(15, 1) << $urandom_range(11));
			if ($urandom_range(1))
				v = -v;
		end
		return v;
	endfunction

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		frac_pair_t p;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			p.op = act_t'($urandom_range(3));
			p.a_num = random_operand();
			p.a_den = random_operand();
			p.b_num = random_operand();
			p.b_den = random_operand();
			send_pair(p);
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_ADD;
		req_if.a_num = '0;
		req_if.a_den = '0;
		req_if.b_num = '0;
		req_if.b_den = '0;
		rsp_if.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: plain cases per action, zero denominator (also with a zero
		// numerator), zero numerator, negative denominators, full-range values.
		send_directed(ACT_ADD, 1, 2, 1, 3);
		send_directed(ACT_SUB, 1, 2, 1, 2);
		send_directed(ACT_MUL, 2, 3, 3, 4);
		send_directed(ACT_DIV, 2, 3, 4, 9);
		send_directed(ACT_ADD, 5, 0, 1, 3);
		send_directed(ACT_DIV, 7, 3, 0, 5);
		send_directed(ACT_MUL, 0, 5, 7, 3);
		send_directed(ACT_DIV, 0, 0, 0, 1);
		send_directed(ACT_ADD, -32768, -32768, -32768, -32768);
		send_directed(ACT_SUB, 32767, -32768, -32768, 32767);
		send_directed(ACT_MUL, -32768, 32767, -32768, 32767);
		send_directed(ACT_DIV, 32767, -32768, -32768, 32767);
		send_directed(ACT_ADD, 1, -1, -1, 1);
		send_directed(ACT_SUB, -1, -1, -1, -1);
		send_directed(ACT_MUL, 32767, 1, 32767, 1);
		send_directed(ACT_DIV, 1, 32767, 32767, 1);
		send_directed(ACT_ADD, 6, 4, 10, 8);
		send_directed(ACT_MUL, -5, 3, 3, -5);
		send_directed(ACT_DIV, 0, 7, 3, 0);
		send_directed(ACT_SUB, 32767, 32767, -32768, -32768);
		send_directed(ACT_ADD, -32768, 1, -32768, 1);
		send_directed(ACT_SUB, -32768, 1, 32767, -32768);
		send_directed(ACT_MUL, 0, 0, 0, 0);
		send_directed(ACT_DIV, -32768, -1, -1, -32768);
		drain();

		// Random phases: no idling, sender idle, receiver stalling, then
		// light idling on both sides. Each phase drains before the next.
		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(65, 0, RANDOM_PER_PHASE);
		run_phase(0, 65, RANDOM_PER_PHASE);
		run_phase(7, 7, RANDOM_PER_PHASE);

		// Let any trailing activity show up before the verdict.
		repeat (300) @(posedge clk);
		if (sb.failures == 0 && sb.pending_fracs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: rational_arith_unit.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_seq.sv
rtl/rau_datapath.sv
rtl/rational_arith_unit.sv
test/testbench.sv
